/* rtl/core/mcs_pkg.sv */
// Shared types, codes and sizes for the motion command sequencer.
package mcs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int AMOUNT_W    = 32;
  localparam int KIND_W      = 2;
  localparam int SLOT_W      = KIND_W + AMOUNT_W;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_TURN    = 2'd0,
    KIND_GO      = 2'd1,
    KIND_WAIT    = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ISSUE_NONE     = 2'd0,
    ISSUE_ANGLE    = 2'd1,
    ISSUE_DISTANCE = 2'd2,
    ISSUE_WAIT     = 2'd3
  } issue_t;

  typedef enum logic [1:0] {
    STAT_IDLE     = 2'd0,
    STAT_RUNNING  = 2'd1,
    STAT_FINISHED = 2'd2
  } stat_t;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIMIT = CFG_IDX_W'(1);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

/* rtl/core/mcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/mcs_ctrl.sv */
// Controller state machine that sequences capture and execution of a transaction.
module mcs_ctrl
  import mcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: cmd.capture = start;
      ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

/* rtl/core/mcs_datapath.sv */
// Datapath: queue pointers, running command state, settle counter and result register.
module mcs_datapath
  import mcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  logic [1:0]            action,
  input  logic [1:0]            command,
  input  logic signed [31:0]    amount,
  input  logic                  angle_done,
  input  logic                  distance_done,
  input  logic [31:0]           now_ms,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  accepted,
  output logic [1:0]            issue,
  output logic signed [31:0]    issue_amount,
  output logic                  regulator_reset,
  output logic [1:0]            status
);

  // Captured transaction fields.
  logic [1:0]  cap_action;
  logic [1:0]  cap_command;
  logic [31:0] cap_amount;
  logic        cap_angle_done;
  logic        cap_distance_done;
  logic [31:0] cap_now;

  logic        enabled;
  logic [7:0]  settle_limit;

  logic [IDX_W-1:0] read_index, read_index_next;
  logic [IDX_W-1:0] write_index, write_index_next;
  logic             running, running_next;
  logic [1:0]       current_kind, current_kind_next;
  logic [7:0]       settle_counter, settle_counter_next;
  logic [31:0]      wake_time, wake_time_next;
  logic [1:0]       status_reg, status_reg_next;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_rd_data;

  logic        res_accepted;
  logic [1:0]  res_issue;
  logic [31:0] res_amount;
  logic        res_reg_reset;

  logic [1:0]  slot_kind;
  logic [31:0] slot_amount;
  logic [31:0] wait_diff;
  logic        flag;
  logic        finish;

  // The read port always looks at the head slot, so its data is ready in the execute cycle.
  mcs_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(write_index),
    .wr_data({cap_command, cap_amount}),
    .rd_addr(read_index),
    .rd_data(ram_rd_data)
  );

  assign slot_kind   = ram_rd_data[SLOT_W-1:AMOUNT_W];
  assign slot_amount = ram_rd_data[AMOUNT_W-1:0];
  assign wait_diff   = cap_now - wake_time;
  assign flag        = (current_kind == KIND_TURN) ? cap_angle_done : cap_distance_done;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_action        <= action;
      cap_command       <= command;
      cap_amount        <= amount;
      cap_angle_done    <= angle_done;
      cap_distance_done <= distance_done;
      cap_now           <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b1;
      settle_limit <= 8'd10;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ENABLED) begin
        enabled <= cfg_data[0];
      end else if (cfg_index == REG_SETTLE_LIMIT) begin
        settle_limit <= cfg_data;
      end
    end
  end

  always_comb begin
    read_index_next     = read_index;
    write_index_next    = write_index;
    running_next        = running;
    current_kind_next   = current_kind;
    settle_counter_next = settle_counter;
    wake_time_next      = wake_time;
    status_reg_next     = status_reg;
    ram_we              = 1'b0;
    res_accepted        = 1'b0;
    res_issue           = ISSUE_NONE;
    res_amount          = '0;
    res_reg_reset       = 1'b0;
    finish              = 1'b0;

    case (cap_action)
      ACT_ADD: begin
        if (cap_command != KIND_INVALID && ring_next(write_index) != read_index) begin
          // The slot is written only in the execute cycle of the add.
          ram_we           = cmd.execute;
          write_index_next = ring_next(write_index);
          res_accepted     = 1'b1;
        end
      end
      ACT_STOP: begin
        read_index_next     = '0;
        write_index_next    = '0;
        running_next        = 1'b0;
        settle_counter_next = '0;
        res_reg_reset       = 1'b1;
      end
      ACT_TICK: begin
        if (enabled) begin
          if (!running) begin
            if (read_index != write_index) begin
              current_kind_next = slot_kind;
              res_amount        = slot_amount;
              case (slot_kind)
                KIND_TURN: res_issue = ISSUE_ANGLE;
                KIND_GO:   res_issue = ISSUE_DISTANCE;
                default: begin
                  res_issue      = ISSUE_WAIT;
                  wake_time_next = cap_now + slot_amount;
                end
              endcase
              read_index_next     = ring_next(read_index);
              running_next        = 1'b1;
              settle_counter_next = '0;
              status_reg_next     = STAT_RUNNING;
            end else begin
              status_reg_next = STAT_IDLE;
            end
          end else begin
            if (current_kind == KIND_TURN || current_kind == KIND_GO) begin
              if (flag) begin
                settle_counter_next = (settle_counter == 8'hFF) ? 8'hFF
                                                                : settle_counter + 8'd1;
              end else begin
                settle_counter_next = '0;
              end
              finish = settle_counter_next > settle_limit;
            end else begin
              // A wait ends once the time has reached the wake time, modulo wrap.
              if (!wait_diff[31]) begin
                finish              = 1'b1;
                settle_counter_next = (settle_limit == 8'hFF) ? 8'hFF
                                                              : settle_limit + 8'd1;
              end else begin
                settle_counter_next = '0;
              end
            end
            if (finish) begin
              running_next    = 1'b0;
              status_reg_next = STAT_FINISHED;
            end
          end
        end
      end
      default: res_accepted = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index     <= '0;
      write_index    <= '0;
      running        <= 1'b0;
      current_kind   <= KIND_TURN;
      settle_counter <= '0;
      wake_time      <= '0;
      status_reg     <= STAT_IDLE;
      done           <= 1'b0;
    end else begin
      done <= cmd.execute;
      if (cmd.execute) begin
        read_index     <= read_index_next;
        write_index    <= write_index_next;
        running        <= running_next;
        current_kind   <= current_kind_next;
        settle_counter <= settle_counter_next;
        wake_time      <= wake_time_next;
        status_reg     <= status_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      accepted        <= res_accepted;
      issue           <= res_issue;
      issue_amount    <= res_amount;
      regulator_reset <= res_reg_reset;
      status          <= status_reg_next;
    end
  end

endmodule

/* rtl/core/motion_command_sequencer.sv */
// Top level of the motion command sequencer: controller, datapath and config port.
// Timing: a transaction accepted with start is captured, then executes, and its result
// shows on the result ports, marked by done, in the cycle after that.
// Start is taken only while idle, so no transaction is accepted while busy is high in
// the execute cycle, which waits on the registered read of the command queue RAM.
// Reset clears the queue pointers, the running command and the status; enabled returns
// to 1 and settle_limit to 10. The receiver cannot stall, so done is never held off.
module motion_command_sequencer
  import mcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Command channel.
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action,
  input  logic [1:0]            command,
  input  logic signed [31:0]    amount,
  input  logic                  angle_done,
  input  logic                  distance_done,
  input  logic [31:0]           now_ms,
  // Result channel.
  output logic                  done,
  output logic                  accepted,
  output logic [1:0]            issue,
  output logic signed [31:0]    issue_amount,
  output logic                  regulator_reset,
  output logic [1:0]            status,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;

  // Configuration registers are plain flops, so a write is always taken at once.
  assign cfg_ready = 1'b1;

  // The controller only sequences: capture on acceptance, then the execute state.
  mcs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  // The datapath holds all architectural state, the queue RAM and the result register.
  mcs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .action         (action),
    .command        (command),
    .amount         (amount),
    .angle_done     (angle_done),
    .distance_done  (distance_done),
    .now_ms         (now_ms),
    .cfg_valid      (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .accepted       (accepted),
    .issue          (issue),
    .issue_amount   (issue_amount),
    .regulator_reset(regulator_reset),
    .status         (status)
  );

endmodule
